>>> rtl/core/ipr_pkg.sv
// shared types and constants for the integer pixel replication upscaler
package ipr_pkg;

   localparam int RGB_W     = 24;
   localparam int SCALE_W   = 7;
   localparam int WIDTH_W   = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 1'd1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   // one decoded item handed from the control front to the emitter
   typedef struct packed {
      logic               from_ram;
      logic [RGB_W-1:0]   rgb;
      logic               row_end;
      logic [1:0]         pad;
      logic [1:0]         status;
      logic [SCALE_W-1:0] count;
   } job_type;

endpackage

>>> rtl/core/integer_pixel_replication_upscaler.sv
// top level of the integer pixel replication upscaler
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, req_red, req_green, req_blue
//  rsp      out        rsp_valid/rsp_stall   rsp_out_red/green/blue, rsp_row_end,
//                                            rsp_pad_bytes, rsp_status, rsp_last
//  csr      in         csr_wr_en             csr_index, csr_wdata
//
//  an incoming pixel gives scale results, one per cycle while the output is not stalled;
//  a tick or an error gives one result; the single output register moving one pixel a cycle sets this
//  a new item is taken in the cycle its predecessor hands over its last result
//  an accepted item is registered in the item stage, then its first result in the output register
//  reset clears counters and handshake state; the line store needs no clearing pass
//  an output stall holds the output register and, through the item stage, req_stall
module integer_pixel_replication_upscaler #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_SCALE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes
   input  logic                          csr_wr_en,
   input  logic [ipr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ipr_pkg::CSR_DAT_W-1:0] csr_wdata,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic                          rsp_row_end,
   output logic [1:0]                    rsp_pad_bytes,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   import ipr_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic             accept;
   logic             busy;
   job_type          job;
   logic             ram_wr_en;
   logic [CW-1:0]    ram_wr_addr;
   logic [RGB_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [CW-1:0]    ram_rd_addr;
   logic [RGB_W-1:0] ram_rd_data;

   // the item stage decides when a new item may enter
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   // counters and decode; state is updated at the input transfer itself
   ipr_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .req_type    (req_type),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .job         (job)
   );

   // line store: pixels write while no replay is owed, ticks read only during
   // replay, so a write and a read never meet in the same cycle
   ipr_ram #(
      .WIDTH (RGB_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // item stage and output register
   ipr_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .job_load      (accept),
      .job           (job),
      .ram_rd_data   (ram_rd_data),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

>>> rtl/core/ipr_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ipr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ipr_ctrl.sv
// config registers, row and replay counters, line store access and item decode
module ipr_ctrl #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_SCALE = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ipr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipr_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  logic                           accept,
   input  logic                           req_type,
   input  logic [7:0]                     req_red,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_blue,
   output logic                           ram_wr_en,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] ram_wr_addr,
   output logic [ipr_pkg::RGB_W-1:0]      ram_wr_data,
   output logic                           ram_rd_en,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] ram_rd_addr,
   output ipr_pkg::job_type               job
);

   import ipr_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = CW + 1;
   localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [WW-1:0]      width_ff, width_in;
   logic [CW-1:0]      column_ff, column_in;
   logic [CW-1:0]      replay_col_ff, replay_col_in;
   logic [RW-1:0]      replays_ff, replays_in;

   logic [SCALE_W-1:0] csr_scale;
   logic [WIDTH_W-1:0] csr_width;
   logic [3:0]         pad_prod;
   logic [3:0]         pad_bytes3;
   logic [1:0]         pad;
   logic               col_end;
   logic               replay_end;
   logic               replaying;

   assign csr_scale = csr_wdata[SCALE_W-1:0];
   assign csr_width = csr_wdata[WIDTH_W-1:0];

   // only the low two bits of width and scale decide the byte count mod 4
   assign pad_prod   = 4'(width_ff[1:0]) * 4'(scale_ff[1:0]);
   assign pad_bytes3 = pad_prod * 4'd3;
   assign pad        = 2'(2'd0 - pad_bytes3[1:0]);

   assign col_end    = (WW'(column_ff) + WW'(1)) >= width_ff;
   assign replay_end = (WW'(replay_col_ff) + WW'(1)) >= width_ff;
   assign replaying  = (replays_ff != '0);

   always_comb begin
      scale_in      = scale_ff;
      width_in      = width_ff;
      column_in     = column_ff;
      replay_col_in = replay_col_ff;
      replays_in    = replays_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      job.from_ram  = 1'b0;
      job.rgb       = '0;
      job.row_end   = 1'b0;
      job.pad       = 2'd0;
      job.status    = STATUS_OK;
      job.count     = SCALE_W'(1);

      // effective values are kept, so saturation happens once per write
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE: begin
               if (csr_scale == '0) begin
                  scale_in = SCALE_W'(1);
               end else if (int'(csr_scale) > MAX_SCALE) begin
                  scale_in = SCALE_W'(MAX_SCALE);
               end else begin
                  scale_in = csr_scale;
               end
            end
            CSR_WIDTH: begin
               if (csr_width == '0) begin
                  width_in = WW'(1);
               end else if (int'(csr_width) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_width);
               end
            end
            default: begin
            end
         endcase
      end

      if (accept) begin
         if (req_type == REQ_PIXEL) begin
            if (replaying) begin
               job.status = STATUS_REFUSED;
            end else begin
               ram_wr_en   = 1'b1;
               job.rgb     = {req_red, req_green, req_blue};
               job.row_end = col_end;
               job.pad     = col_end ? pad : 2'd0;
               job.count   = scale_ff;
               if (col_end) begin
                  column_in     = '0;
                  replays_in    = RW'(scale_ff - SCALE_W'(1));
                  replay_col_in = '0;
               end else begin
                  column_in = column_ff + CW'(1);
               end
            end
         end else begin
            if (!replaying) begin
               job.status = STATUS_EMPTY;
            end else begin
               ram_rd_en    = 1'b1;
               job.from_ram = 1'b1;
               job.row_end  = replay_end;
               job.pad      = replay_end ? pad : 2'd0;
               if (replay_end) begin
                  replay_col_in = '0;
                  replays_in    = replays_ff - RW'(1);
               end else begin
                  replay_col_in = replay_col_ff + CW'(1);
               end
            end
         end
      end
   end

   assign ram_wr_addr = column_ff;
   assign ram_wr_data = {req_red, req_green, req_blue};
   assign ram_rd_addr = replay_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_W'(1);
         width_ff      <= WW'(1);
         column_ff     <= '0;
         replay_col_ff <= '0;
         replays_ff    <= '0;
      end else begin
         scale_ff      <= scale_in;
         width_ff      <= width_in;
         column_ff     <= column_in;
         replay_col_ff <= replay_col_in;
         replays_ff    <= replays_in;
      end
   end

endmodule

>>> rtl/core/ipr_emit.sv
// holds one decoded item and emits its results into the output register
module ipr_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_load,
   input  ipr_pkg::job_type              job,
   input  logic [ipr_pkg::RGB_W-1:0]     ram_rd_data,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic                          rsp_row_end,
   output logic [1:0]                    rsp_pad_bytes,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   import ipr_pkg::*;

   logic               job_valid_ff, job_valid_in;
   job_type            job_ff, job_in;
   logic [SCALE_W-1:0] cnt_ff, cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic [RGB_W-1:0]   out_rgb_ff, out_rgb_in;
   logic               out_row_end_ff, out_row_end_in;
   logic [1:0]         out_pad_ff, out_pad_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;

   logic               emit_go;
   logic               final_one;
   logic [RGB_W-1:0]   rgb;

   assign emit_go   = job_valid_ff && (!out_valid_ff || !rsp_stall);
   assign final_one = (cnt_ff == SCALE_W'(1));
   assign busy      = job_valid_ff && !(emit_go && final_one);
   // replayed pixels come straight from the ram read register, which holds
   assign rgb       = job_ff.from_ram ? ram_rd_data : job_ff.rgb;

   always_comb begin
      job_valid_in   = job_valid_ff;
      job_in         = job_ff;
      cnt_in         = cnt_ff;
      out_valid_in   = out_valid_ff;
      out_rgb_in     = out_rgb_ff;
      out_row_end_in = out_row_end_ff;
      out_pad_in     = out_pad_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;

      if (job_load) begin
         job_valid_in = 1'b1;
         job_in       = job;
         cnt_in       = job.count;
      end else if (emit_go && final_one) begin
         job_valid_in = 1'b0;
      end else if (emit_go) begin
         cnt_in = cnt_ff - SCALE_W'(1);
      end

      if (emit_go) begin
         out_valid_in   = 1'b1;
         out_rgb_in     = rgb;
         out_row_end_in = final_one && job_ff.row_end;
         out_pad_in     = final_one ? job_ff.pad : 2'd0;
         out_status_in  = job_ff.status;
         out_last_in    = final_one;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff         <= job_in;
      cnt_ff         <= cnt_in;
      out_rgb_ff     <= out_rgb_in;
      out_row_end_ff <= out_row_end_in;
      out_pad_ff     <= out_pad_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_rgb_ff[23:16];
   assign rsp_out_green = out_rgb_ff[15:8];
   assign rsp_out_blue  = out_rgb_ff[7:0];
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_pad_bytes = out_pad_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last      = out_last_ff;

endmodule

>>> bench/upscale_checker.sv
// output checker for the pixel replication upscaler: predicts and compares every result
module upscale_checker
   import ipr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_type,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [7:0]           rsp_out_red,
   input  logic [7:0]           rsp_out_green,
   input  logic [7:0]           rsp_out_blue,
   input  logic                 rsp_row_end,
   input  logic [1:0]           rsp_pad_bytes,
   input  logic [1:0]           rsp_status,
   input  logic                 rsp_last,
   output int                   mismatches,
   output int                   pending,
   output int                   checked,
   output logic                 replay_busy,
   output logic                 row_open
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 4096;
   localparam int SCALE_CAP   = 64;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic [1:0] pad;
      logic [1:0] status;
      logic       last;
   } out_pixel_type;

   logic [SCALE_W-1:0] scale_q;
   logic [WIDTH_W-1:0] width_q;
   logic [RGB_W-1:0]   line_mem [STORE_DEPTH];
   logic [11:0]        column;
   logic [5:0]         replays_left;
   logic [11:0]        replay_col;
   out_pixel_type      upscaled_q [$];

   function automatic int active_scale();
      if (scale_q == '0) return 1;
      if (int'(scale_q) > SCALE_CAP) return SCALE_CAP;
      return int'(scale_q);
   endfunction

   function automatic int active_width();
      if (width_q == '0) return 1;
      if (int'(width_q) > STORE_DEPTH) return STORE_DEPTH;
      return int'(width_q);
   endfunction

   // zero bytes that bring a row of width*scale rgb pixels to a multiple of four
   function automatic logic [1:0] row_padding();
      int bytes;
      bytes = active_width() * active_scale() * 3;
      return 2'((4 - (bytes % 4)) % 4);
   endfunction

   function automatic void upscale_item(input logic kind, input logic [RGB_W-1:0] rgb);
      int            w;
      int            s;
      logic          ends;
      logic [1:0]    pad;
      out_pixel_type px;
      w = active_width();
      s = active_scale();
      px = '0;
      px.last = 1'b1;
      if (kind == REQ_PIXEL) begin
         if (replays_left != '0) begin
            px.status = STATUS_REFUSED;
            upscaled_q.push_back(px);
         end else begin
            line_mem[column] = rgb;
            ends = (int'(column) + 1 >= w);
            pad = ends ? row_padding() : 2'd0;
            for (int k = 0; k < s; k++) begin
               px = '0;
               {px.red, px.green, px.blue} = rgb;
               px.status = STATUS_OK;
               if (k == s - 1) begin
                  px.row_end = ends;
                  px.pad = pad;
                  px.last = 1'b1;
               end
               upscaled_q.push_back(px);
            end
            if (ends) begin
               column = '0;
               replays_left = 6'(s - 1);
               replay_col = '0;
            end else begin
               column = column + 12'd1;
            end
         end
      end else begin
         if (replays_left == '0) begin
            px.status = STATUS_EMPTY;
            upscaled_q.push_back(px);
         end else begin
            ends = (int'(replay_col) + 1 >= w);
            {px.red, px.green, px.blue} = line_mem[replay_col];
            px.row_end = ends;
            px.pad = ends ? row_padding() : 2'd0;
            px.status = STATUS_OK;
            upscaled_q.push_back(px);
            if (ends) begin
               replay_col = '0;
               replays_left = replays_left - 6'd1;
            end else begin
               replay_col = replay_col + 12'd1;
            end
         end
      end
   endfunction

   function automatic void report(input string what, input out_pixel_type want,
                                  input out_pixel_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("%s at result %0d: expected rgb %02h%02h%02h row_end %0d pad %0d %s",
                  what, checked, want.red, want.green, want.blue, want.row_end, want.pad,
                  $sformatf("status %0d last %0d", want.status, want.last));
         $display("   got rgb %02h%02h%02h row_end %0d pad %0d status %0d last %0d",
                  got.red, got.green, got.blue, got.row_end, got.pad, got.status,
                  got.last);
      end
   endfunction

   always @(posedge clock) begin
      out_pixel_type got;
      out_pixel_type want;
      if (reset) begin
         scale_q = SCALE_W'(1);
         width_q = WIDTH_W'(1);
         column = '0;
         replays_left = '0;
         replay_col = '0;
         upscaled_q.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_SCALE) scale_q = csr_wdata[SCALE_W-1:0];
            else if (csr_index == CSR_WIDTH) width_q = csr_wdata[WIDTH_W-1:0];
         end
         if (req_valid && !req_stall) upscale_item(req_type, {req_red, req_green, req_blue});
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_row_end, rsp_pad_bytes,
                   rsp_status, rsp_last};
            if (upscaled_q.size() == 0) begin
               report("unexpected result", '0, got);
            end else begin
               want = upscaled_q.pop_front();
               if (got != want) report("mismatch", want, got);
            end
            checked++;
         end
      end
      pending = upscaled_q.size();
      replay_busy = (replays_left != '0);
      row_open = (column != '0);
   end

endmodule

>>> bench/tb_top.sv
// testbench top for the upscaler: clock, reset, stimulus and the final verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ipr_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // idle cycles that drain adds after every expected result has been checked
   localparam int SETTLE_CYCLES = 4;
   localparam int SEGMENT_ITEMS = 8;
   localparam int NOISE_PCT     = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SCALE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_PIXEL;
   logic [7:0]           req_red = '0;
   logic [7:0]           req_green = '0;
   logic [7:0]           req_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_out_red;
   logic [7:0]           rsp_out_green;
   logic [7:0]           rsp_out_blue;
   logic                 rsp_row_end;
   logic [1:0]           rsp_pad_bytes;
   logic [1:0]           rsp_status;
   logic                 rsp_last;

   int   mismatch_count;
   int   pending_count;
   int   checked_count;
   logic replay_busy;
   logic row_open;

   // idle and stall odds in percent, changed per phase
   int idle_pct = 10;
   int stall_pct = 78;
   int items_sent = 0;
   int config_count = 0;
   int cycles = 0;

   integer_pixel_replication_upscaler dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   upscale_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .mismatches    (mismatch_count),
      .pending       (pending_count),
      .checked       (checked_count),
      .replay_busy   (replay_busy),
      .row_open      (row_open)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung block or a lost result ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver back-pressure, one fresh draw per cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one transfer on the request channel; entered and left at a falling edge,
   // valid stays high on return so back-to-back items need no extra toggle
   task automatic send_item(input logic kind, input logic [RGB_W-1:0] rgb);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      {req_red, req_green, req_blue} <= rgb;
      // stall is read before the edge updates land, so this sees the accepting edge
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // sender holds off until every expected result has been checked
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // both registers are written back to back while the block is idle
   task automatic set_config(input logic [CSR_DAT_W-1:0] scale_word,
                             input logic [CSR_DAT_W-1:0] width_word);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCALE;
      csr_wdata <= scale_word;
      @(negedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= width_word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      config_count++;
   endtask

   // mostly well-formed traffic: pixels for an open row, ticks while a replay is owed,
   // with a few refused pixels and empty ticks mixed in; stops at a row boundary
   task automatic run_rows(input int target);
      int   sent;
      logic kind;
      sent = 0;
      while (sent < target || replay_busy || row_open) begin
         if (replay_busy) kind = ($urandom_range(99) < NOISE_PCT) ? REQ_PIXEL : REQ_TICK;
         else kind = ($urandom_range(99) < NOISE_PCT) ? REQ_TICK : REQ_PIXEL;
         send_item(kind, RGB_W'($urandom()));
         sent++;
      end
   endtask

   initial begin
      int pick;
      int scale_raw;
      int scale_eff;
      int width_raw;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, reset values scale 1 width 1 ----
      // tick with nothing owed, its color must be ignored
      send_item(REQ_TICK, 24'hFFFFFF);
      // one-pixel row, three bytes need one byte of padding
      send_item(REQ_PIXEL, 24'h000000);

      // scale word with junk above the field, width two
      set_config(13'h1F83, 13'd2);
      send_item(REQ_PIXEL, 24'hFFFFFF);
      send_item(REQ_PIXEL, 24'h123456);
      // pixel arriving while the row is owed twice more gets refused
      send_item(REQ_PIXEL, 24'hABCDEF);
      repeat (4) send_item(REQ_TICK, RGB_W'($urandom()));
      // replay finished, so this tick finds nothing owed
      send_item(REQ_TICK, 24'h000000);

      // zero scale and zero width both act as one
      set_config(13'd0, 13'd0);
      send_item(REQ_PIXEL, 24'h5A5A5A);

      // width above the store saturates; then lower it under the current column
      set_config(13'd2, 13'd8191);
      repeat (3) send_item(REQ_PIXEL, RGB_W'($urandom()));
      set_config(13'd2, 13'd2);
      send_item(REQ_PIXEL, RGB_W'($urandom()));
      repeat (2) send_item(REQ_TICK, RGB_W'($urandom()));

      // lower the width in the middle of a replay
      set_config(13'd3, 13'd4);
      repeat (4) send_item(REQ_PIXEL, RGB_W'($urandom()));
      repeat (2) send_item(REQ_TICK, RGB_W'($urandom()));
      set_config(13'd3, 13'd1);
      repeat (2) send_item(REQ_TICK, RGB_W'($urandom()));

      // scale above the cap saturates to 64; the owed replays open the random part
      set_config(13'd100, 13'd1);
      send_item(REQ_PIXEL, 24'hAA55AA);

      // random part: receiver-heavy stall, then sender-heavy idle, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               idle_pct = 10;
               stall_pct = 78;
            end
            1: begin
               idle_pct = 78;
               stall_pct = 10;
            end
            default: begin
               idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            // new settings only at a row boundary with nothing owed
            if (!replay_busy && !row_open) begin
               pick = $urandom_range(99);
               if (pick < 50) scale_raw = $urandom_range(3, 1);
               else if (pick < 80) scale_raw = $urandom_range(8, 4);
               else if (pick < 92) scale_raw = $urandom_range(64, 9);
               else scale_raw = $urandom_range(1) ? 0 : $urandom_range(127, 65);
               scale_eff = (scale_raw == 0) ? 1 : ((scale_raw > 64) ? 64 : scale_raw);
               // big scales get a one-pixel row so a row stays short
               if (scale_eff > 8) width_raw = 1;
               else if ($urandom_range(99) < 70) width_raw = $urandom_range(8, 0);
               else width_raw = $urandom_range(16, 9);
               set_config({6'($urandom()), 7'(scale_raw)}, 13'(width_raw));
            end
            run_rows(SEGMENT_ITEMS);
         end
      end

      drain();
      $display("covered %0d input items and %0d checked output pixels over %0d settings",
               items_sent, checked_count, config_count);
      $display("scales 1 to 64 with out-of-range words, widths 1 to 4096, refusals, empty ticks");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
